// ----- src/bezier_curve_sampler_macros.svh -----
// Assertion macros shared by the curve sampler modules.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef BEZIER_CURVE_SAMPLER_MACROS_SVH
`define BEZIER_CURVE_SAMPLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BCS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BCS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define BCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- src/bcs_pkg.sv -----
package bcs_pkg;

    // Coordinate and fraction formats.
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;

    // Interpolation weight t in unsigned Q1.16; one is exactly representable.
    localparam int          T_W     = 17;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Steps per segment register.
    localparam int         STEPS_W     = 4;
    localparam logic [3:0] STEPS_RESET = 4'd4;
    localparam logic [3:0] STEPS_MIN   = 4'd1;
    localparam logic [3:0] STEPS_MAX   = 4'd9;

    // Point store limits; field widths cover the largest allowed store.
    localparam int MAX_POINTS_DEF = 8;
    localparam int CNT_W          = 4;
    localparam int SLOT_W         = 3;

    // Total step count, up to nine steps times seven segments.
    localparam int NS_W = 6;

    // Command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // One input beat.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } t_point_in;

    // One output beat.
    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_z;
        logic                      last_sample;
    } t_sample_out;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_point_in         point;
        logic              store;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } t_cmd;

endpackage

// ----- src/bcs_front.sv -----
module bcs_front #(
    parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcs_pkg::t_point_in i_point,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_full,
    output logic               o_push,
    output bcs_pkg::t_cmd      o_cmd
);
    import bcs_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             room;

    // A beat is taken whenever the queue has a free entry.
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the point: store it if there is room, and record the fill.
    always_comb begin
        room            = r_count < CNT_W'(MAX_POINTS);
        o_cmd.point     = i_point;
        o_cmd.store     = room;
        o_cmd.slot      = r_count[SLOT_W-1:0];
        o_cmd.count     = room ? r_count + 1'b1 : r_count;
        n_count         = r_count;
        if (o_push) begin
            if (i_point.last_point) begin
                n_count = '0;
            end else begin
                n_count = o_cmd.count;
            end
        end
    end

    // Stored point count; the last point of a curve empties the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ----- src/bcs_queue.sv -----
`include "bezier_curve_sampler_macros.svh"

module bcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bcs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output bcs_pkg::t_cmd o_cmd,
    output logic          o_valid,
    output logic          o_full
);
    import bcs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_valid = r_fill != '0;
    assign o_full  = r_fill == FILL_W'(QUEUE_DEPTH);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    `BCS_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `BCS_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `BCS_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, i_push && !i_pop, o_valid, "pushed entry lost")

endmodule

// ----- src/bcs_back.sv -----
`include "bezier_curve_sampler_macros.svh"

module bcs_back #(
    parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bcs_pkg::STEPS_W-1:0]   i_steps,
    input  bcs_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    output bcs_pkg::t_sample_out          o_sample,
    output logic                          o_valid,
    input  logic                          i_stall
);
    import bcs_pkg::*;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int DIV_CNT_W = $clog2(T_W);
    localparam int P_W       = T_W + COORD_W + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_DROP = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Control point store.
    logic [COORD_W-1:0] r_sx [MAX_POINTS];
    logic [COORD_W-1:0] r_sy [MAX_POINTS];
    logic [COORD_W-1:0] r_sz [MAX_POINTS];

    // De Casteljau working line; only the two head entries feed the multipliers.
    logic [COORD_W-1:0] r_wx [MAX_POINTS];
    logic [COORD_W-1:0] r_wy [MAX_POINTS];
    logic [COORD_W-1:0] r_wz [MAX_POINTS];

    logic [CNT_W-1:0]     r_n;
    logic [NS_W-1:0]      r_ns;
    logic [NS_W-1:0]      r_k;
    logic [T_W-1:0]       r_t_q;
    logic [NS_W-1:0]      r_t_r;
    logic [NS_W-1:0]      r_div_rem;
    logic [T_W-1:0]       r_div_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [IDX_W-1:0]     r_lvl;
    logic [IDX_W-1:0]     r_idx;
    logic [COORD_W-1:0]   r_ax;
    logic [COORD_W-1:0]   r_ay;
    logic [COORD_W-1:0]   r_az;
    logic signed [P_W-1:0] r_px;
    logic signed [P_W-1:0] r_py;
    logic signed [P_W-1:0] r_pz;
    t_sample_out          r_out;
    logic                 r_out_valid;

    logic [STEPS_W-1:0]      steps_sat;
    logic [2*CNT_W-1:0]      ns_full;
    logic [NS_W-1:0]         ns_cmd;
    logic                    emit_fire;
    logic                    last_smp;
    logic [NS_W:0]           div_rem_sh;
    logic                    div_ge;
    logic [NS_W-1:0]         div_rem_nxt;
    logic [NS_W:0]           t_sum;
    logic                    t_wrap;
    logic signed [T_W:0]     t_s;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dz;
    logic [COORD_W-1:0]      ux;
    logic [COORD_W-1:0]      uy;
    logic [COORD_W-1:0]      uz;

    assign o_sample  = r_out;
    assign o_valid   = r_out_valid;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Step count for the curve and handshake of the output register.
    always_comb begin
        if (i_steps < STEPS_MIN) begin
            steps_sat = STEPS_MIN;
        end else if (i_steps > STEPS_MAX) begin
            steps_sat = STEPS_MAX;
        end else begin
            steps_sat = i_steps;
        end
        ns_full   = {{CNT_W{1'b0}}, steps_sat} * {{STEPS_W{1'b0}}, i_cmd.count - 1'b1};
        ns_cmd    = ns_full[NS_W-1:0];
        emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
        last_smp  = r_k == r_ns;
    end

    // One bit of the restoring division of 1.0 by the step count.
    always_comb begin
        div_rem_sh  = {r_div_rem, r_div_quo[T_W-1]};
        div_ge      = div_rem_sh >= {1'b0, r_ns};
        div_rem_nxt = div_ge ? NS_W'(div_rem_sh - {1'b0, r_ns}) : div_rem_sh[NS_W-1:0];
    end

    // Next t: add quotient and remainder, carrying when the remainder wraps.
    always_comb begin
        t_sum  = {1'b0, r_t_r} + {1'b0, r_div_rem};
        t_wrap = t_sum >= {1'b0, r_ns};
    end

    // Interpolation datapath: a + floor(t * (b - a) / 2^16).
    always_comb begin
        t_s = $signed({1'b0, r_t_q});
        dx  = $signed({r_wx[1][COORD_W-1], r_wx[1]}) - $signed({r_wx[0][COORD_W-1], r_wx[0]});
        dy  = $signed({r_wy[1][COORD_W-1], r_wy[1]}) - $signed({r_wy[0][COORD_W-1], r_wy[0]});
        dz  = $signed({r_wz[1][COORD_W-1], r_wz[1]}) - $signed({r_wz[0][COORD_W-1], r_wz[0]});
        ux  = r_ax + r_px[COORD_W+FRAC_W-1:FRAC_W];
        uy  = r_ay + r_py[COORD_W+FRAC_W-1:FRAC_W];
        uz  = r_az + r_pz[COORD_W+FRAC_W-1:FRAC_W];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.point.last_point) begin
                    n_state = (ns_cmd == '0) ? S_LOAD : S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(T_W - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (r_n == CNT_W'(1)) ? S_EMIT : S_MUL;
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_idx == r_lvl - 1'b1) ? S_DROP : S_MUL;
            end
            S_DROP: begin
                n_state = (r_lvl == IDX_W'(1)) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (emit_fire) begin
                    n_state = last_smp ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Point store write.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.store) begin
            r_sx[i_cmd.slot[IDX_W-1:0]] <= i_cmd.point.point_x;
            r_sy[i_cmd.slot[IDX_W-1:0]] <= i_cmd.point.point_y;
            r_sz[i_cmd.slot[IDX_W-1:0]] <= i_cmd.point.point_z;
        end
    end

    // Datapath registers, advanced by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.point.last_point) begin
                    r_n       <= i_cmd.count;
                    r_ns      <= ns_cmd;
                    r_k       <= '0;
                    r_t_q     <= '0;
                    r_t_r     <= '0;
                    r_div_rem <= '0;
                    r_div_quo <= ONE_Q16;
                    r_div_cnt <= '0;
                end
            end
            S_DIV: begin
                r_div_rem <= div_rem_nxt;
                r_div_quo <= {r_div_quo[T_W-2:0], div_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            S_LOAD: begin
                for (int p = 0; p < MAX_POINTS; p++) begin
                    r_wx[p] <= r_sx[p];
                    r_wy[p] <= r_sy[p];
                    r_wz[p] <= r_sz[p];
                end
                r_lvl <= IDX_W'(r_n - 1'b1);
                r_idx <= '0;
            end
            S_MUL: begin
                r_ax <= r_wx[0];
                r_ay <= r_wy[0];
                r_az <= r_wz[0];
                r_px <= t_s * dx;
                r_py <= t_s * dy;
                r_pz <= t_s * dz;
            end
            S_ADD: begin
                // Pop the head, push the new point behind the remaining ones.
                for (int p = 0; p < MAX_POINTS - 1; p++) begin
                    if (IDX_W'(p) == r_lvl) begin
                        r_wx[p] <= ux;
                        r_wy[p] <= uy;
                        r_wz[p] <= uz;
                    end else begin
                        r_wx[p] <= r_wx[p+1];
                        r_wy[p] <= r_wy[p+1];
                        r_wz[p] <= r_wz[p+1];
                    end
                end
                if (r_lvl == IDX_W'(MAX_POINTS - 1)) begin
                    r_wx[MAX_POINTS-1] <= ux;
                    r_wy[MAX_POINTS-1] <= uy;
                    r_wz[MAX_POINTS-1] <= uz;
                end
                r_idx <= r_idx + 1'b1;
            end
            S_DROP: begin
                // Discard the last point of the finished level.
                for (int p = 0; p < MAX_POINTS - 1; p++) begin
                    r_wx[p] <= r_wx[p+1];
                    r_wy[p] <= r_wy[p+1];
                    r_wz[p] <= r_wz[p+1];
                end
                r_lvl <= r_lvl - 1'b1;
                r_idx <= '0;
            end
            S_EMIT: begin
                if (emit_fire) begin
                    r_out.sample_x    <= r_wx[0];
                    r_out.sample_y    <= r_wy[0];
                    r_out.sample_z    <= r_wz[0];
                    r_out.last_sample <= last_smp;
                    if (!last_smp) begin
                        r_k <= r_k + 1'b1;
                        if (t_wrap) begin
                            r_t_r <= NS_W'(t_sum - {1'b0, r_ns});
                            r_t_q <= r_t_q + r_div_quo + 1'b1;
                        end else begin
                            r_t_r <= t_sum[NS_W-1:0];
                            r_t_q <= r_t_q + r_div_quo;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `BCS_ASSERT_IMPL(a_final_t_one, i_clk, i_rst_n, emit_fire && last_smp && (r_ns != '0), r_t_q == ONE_Q16, "final sample not at t of one")
    `BCS_ASSERT_IMPL(a_t_rem_bound, i_clk, i_rst_n, (r_state == S_EMIT) && (r_ns != '0), r_t_r < r_ns, "t remainder out of range")
    `BCS_ASSERT_IMPL(a_level_valid, i_clk, i_rst_n, (r_state == S_MUL) || (r_state == S_ADD), (r_lvl != '0) && (r_idx < r_lvl), "interpolation index out of level")

endmodule

// ----- src/bezier_curve_sampler.sv -----
// Bezier curve sampler: control points arrive one per beat and are stored (at most
// MAX_POINTS; further points are dropped); the beat marked last_point starts the
// evaluation of steps*(n-1)+1 samples by de Casteljau interpolation at t = k/nsteps
// in unsigned Q1.16, with steps the register value held to 1..9. A point beat that
// does not end a curve passes through a two-entry command queue, so loading runs at one
// point per clock while the queue has room. The last point starts a bit-serial division
// that forms the t increment (skipped for a single point); then for each sample the n
// stored points are reloaded, every interpolation uses the one multiplier per axis in a
// multiply state and an add state, and each level of the triangle ends in a drop state.
// Up to two further points are queued while a curve is sampled. Write steps_per_segment
// only while no curve is in progress. No clearing pass is needed after reset.
module bezier_curve_sampler #(
    parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bcs_pkg::t_point_in          i_point,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cfg_we,
    input  logic [bcs_pkg::STEPS_W-1:0] i_cfg_data,
    output bcs_pkg::t_sample_out        o_sample,
    output logic                        o_valid,
    input  logic                        i_stall
);
    import bcs_pkg::*;

    logic [STEPS_W-1:0] r_steps;
    logic               push;
    t_cmd               push_cmd;
    logic               q_full;
    t_cmd               q_cmd;
    logic               q_valid;
    logic               q_pop;

    // Steps per segment register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            r_steps <= i_cfg_data;
        end
    end

    // Front end: takes point beats and classifies them.
    bcs_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Command queue.
    bcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Back end: point store and curve evaluation.
    bcs_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_steps     (r_steps),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .o_sample    (o_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

endmodule

// ----- tb/sv/bezier_curve_sampler_tb.sv -----
`timescale 1ns / 100ps

module bezier_curve_sampler_tb;

    import bcs_pkg::*;

    localparam int          MAX_PTS     = MAX_POINTS_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned IDLE_WAIT   = 40;
    localparam int unsigned DRAIN_WAIT  = 200;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_PTS   = 32;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    t_point_in          pt_beat  = '0;
    logic               pt_valid = 1'b0;
    logic               pt_stall;
    logic               cfg_we   = 1'b0;
    logic [STEPS_W-1:0] cfg_data = '0;
    t_sample_out        smp_beat;
    logic               smp_valid;
    logic               smp_stall = 1'b0;

    // Point beats waiting for the driver, and samples the curve math says must come out.
    t_point_in   point_queue[$];
    t_sample_out curve_samples_due[$];

    // Shadow of the control point store and the step register.
    logic signed [COORD_W-1:0] ctl_x [MAX_PTS];
    logic signed [COORD_W-1:0] ctl_y [MAX_PTS];
    logic signed [COORD_W-1:0] ctl_z [MAX_PTS];
    int unsigned               ctl_count = 0;
    logic [STEPS_W-1:0]        steps_reg = STEPS_RESET;

    int unsigned beats_queued = 0;
    int unsigned beats_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    logic        pt_took      = 1'b0;
    logic        hold_armed   = 1'b0;

    bezier_curve_sampler dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_point    (pt_beat),
        .i_valid    (pt_valid),
        .o_stall    (pt_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_sample   (smp_beat),
        .o_valid    (smp_valid),
        .i_stall    (smp_stall)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // One interpolation step: floor(((1 - t) * a + t * b)), t in Q1.16.
    function automatic longint lerp_q16(longint a, longint b, int unsigned t);
        longint acc;
        acc = (longint'(ONE_Q16) - longint'(t)) * a + longint'(t) * b;
        return acc >>> FRAC_W;
    endfunction

    // Evaluate every sample of the stored curve and queue it as due.
    function automatic void sample_curve();
        int unsigned steps;
        int unsigned nsteps;
        int unsigned t;
        longint      wx [MAX_PTS];
        longint      wy [MAX_PTS];
        longint      wz [MAX_PTS];
        t_sample_out s;
        steps = steps_reg;
        if (steps < STEPS_MIN) steps = STEPS_MIN;
        if (steps > STEPS_MAX) steps = STEPS_MAX;
        nsteps = steps * (ctl_count - 1);
        for (int unsigned k = 0; k <= nsteps; k++) begin
            t = (nsteps == 0) ? 0 : (k * ONE_Q16) / nsteps;
            for (int i = 0; i < ctl_count; i++) begin
                wx[i] = longint'(ctl_x[i]);
                wy[i] = longint'(ctl_y[i]);
                wz[i] = longint'(ctl_z[i]);
            end
            for (int j = ctl_count - 1; j > 0; j--) begin
                for (int i = 0; i < j; i++) begin
                    wx[i] = lerp_q16(wx[i], wx[i + 1], t);
                    wy[i] = lerp_q16(wy[i], wy[i + 1], t);
                    wz[i] = lerp_q16(wz[i], wz[i + 1], t);
                end
            end
            s.sample_x    = wx[0][COORD_W-1:0];
            s.sample_y    = wy[0][COORD_W-1:0];
            s.sample_z    = wz[0][COORD_W-1:0];
            s.last_sample = (k == nsteps);
            curve_samples_due.insert(curve_samples_due.size(), s);
        end
    endfunction

    // Store an accepted point; the last one of a curve triggers the samples.
    function automatic void take_point(t_point_in p);
        if (ctl_count < MAX_PTS) begin
            ctl_x[ctl_count] = p.point_x;
            ctl_y[ctl_count] = p.point_y;
            ctl_z[ctl_count] = p.point_z;
            ctl_count++;
        end
        if (p.last_point) begin
            sample_curve();
            ctl_count = 0;
        end
    endfunction

    // Compare one accepted sample beat with the oldest one due.
    function automatic void check_sample(t_sample_out got);
        t_sample_out want;
        if (curve_samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample: x=%h y=%h z=%h last=%b",
                         got.sample_x, got.sample_y, got.sample_z, got.last_sample);
        end else begin
            want = curve_samples_due.pop_front();
            if (got.sample_x !== want.sample_x || got.sample_y !== want.sample_y ||
                got.sample_z !== want.sample_z || got.last_sample !== want.last_sample) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: exp x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                             want.sample_x, want.sample_y, want.sample_z, want.last_sample,
                             got.sample_x, got.sample_y, got.sample_z, got.last_sample);
            end
        end
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates: range extremes, small values around zero, or any 32-bit word.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                3: return 32'shFFFF_FFFF;
                default: return 32'sh0001_0000;
            endcase
        end
        if (r < 40) return $signed(32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20));
        return $signed(32'($urandom));
    endfunction

    function automatic void push_point(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y,
                                       logic signed [COORD_W-1:0] z, logic last);
        t_point_in p;
        p.point_x    = x;
        p.point_y    = y;
        p.point_z    = z;
        p.last_point = last;
        point_queue.insert(point_queue.size(), p);
        beats_queued++;
    endfunction

    // Queue one curve of random points; returns how many of them get stored.
    function automatic int unsigned push_curve(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            push_point(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
        return (len > MAX_PTS) ? MAX_PTS : len;
    endfunction

    // Curve lengths are mostly short; a few overflow the store.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return 1;
        if (r < 70) return $urandom_range(2, 4);
        if (r < 92) return $urandom_range(5, MAX_PTS);
        return $urandom_range(MAX_PTS + 1, MAX_PTS + 3);
    endfunction

    // Point beat driver: holds a stalled beat, otherwise inserts gaps or sends the next point.
    always @(negedge clk) begin : point_driver
        int unsigned gap;
        int unsigned calm;
        if (!rst_n) begin
            pt_valid <= 1'b0;
        end else if (pt_valid && !pt_took) begin
            // Beat still waiting for the block.
        end else if (gap != 0) begin
            gap--;
            pt_valid <= 1'b0;
        end else if (point_queue.size() != 0) begin
            pt_beat  <= point_queue.pop_front();
            pt_valid <= 1'b1;
            if (calm != 0) begin
                calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                calm = $urandom_range(10, 40);
            end else begin
                gap = pick_gap();
            end
        end else begin
            pt_valid <= 1'b0;
        end
    end

    // Sample receiver stall: random bursts, quiet stretches, and one long hold-off.
    always @(negedge clk) begin : sample_stall_driver
        int unsigned hold_left;
        int unsigned run;
        int unsigned calm;
        if (hold_armed && smp_valid) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            smp_stall <= 1'b1;
        end else if (run != 0) begin
            run--;
            smp_stall <= 1'b1;
        end else if (calm != 0) begin
            calm--;
            smp_stall <= 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            smp_stall <= 1'b0;
        end else begin
            run = pick_gap();
            if (run != 0) begin
                run--;
                smp_stall <= 1'b1;
            end else begin
                smp_stall <= 1'b0;
            end
        end
    end

    // Monitor: check sample beats and feed accepted point beats to the predictor.
    always @(posedge clk) begin
        if (rst_n) begin
            if (smp_valid && !smp_stall) check_sample(smp_beat);
            if (pt_valid && !pt_stall) begin
                take_point(pt_beat);
                beats_taken++;
            end
        end
        pt_took <= rst_n && pt_valid && !pt_stall;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Wait until every point is taken and every sample is out, then let the block go idle.
    task automatic settle();
        while (beats_taken != beats_queued || curve_samples_due.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_steps(logic [STEPS_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        steps_reg = v;
    endtask

    initial begin
        logic [STEPS_W-1:0] fixed_steps [5];
        logic [STEPS_W-1:0] steps;
        int unsigned        loaded;
        fixed_steps = '{4'd1, 4'd9, 4'd0, 4'd15, 4'd10};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed curves at the reset step count.
        // A single point comes back unchanged as the only sample.
        push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1'b1);
        // Two points at opposite range extremes.
        push_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b0);
        push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 1'b1);
        // Full store: the extra points and the point on the closing beat are dropped.
        for (int i = 0; i < MAX_PTS + 2; i++)
            push_point(pick_coord(), pick_coord(), pick_coord(), 1'b0);
        push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        // Small three-point curve with negative and positive values.
        push_point(-32'sh0003_8000, 32'sh0001_0000, 32'sh0000_0000, 1'b0);
        push_point(32'sh0002_4000, -32'sh0000_0001, 32'sh0005_0000, 1'b0);
        push_point(32'sh0000_0003, 32'sh7FFF_0000, -32'sh7FFF_0000, 1'b1);

        // Random phases, each at its own step count, extremes first.
        for (int p = 0; p < 8; p++) begin
            settle();
            steps = (p < 5) ? fixed_steps[p] : 4'($urandom_range(0, 15));
            write_steps(steps);
            @(posedge clk);
            if (p == 1) hold_armed = 1'b1;
            loaded = 0;
            while (loaded < PHASE_PTS) loaded += push_curve(pick_len());
        end

        while (beats_taken != beats_queued || curve_samples_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0 && curve_samples_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
